// ===== rtl/kcl_pkg.sv =====
// ----------------------------------------------------------------------------
// kcl_pkg
// Types and constants shared by the keypad code lock core and its step logic.
// ----------------------------------------------------------------------------
package kcl_pkg;

  // code geometry: four BCD digits per code
  localparam int CODE_DIGITS = 4;
  localparam int DIGIT_W     = 4;
  localparam int CODE_W      = CODE_DIGITS * DIGIT_W;
  localparam int COUNT_W     = 3;
  localparam int CFG_IDX_W   = 1;

  // key kinds carried on the input tuser
  typedef enum logic [1:0] {
    CMD_DIGIT = 2'd0,
    CMD_CLEAR = 2'd1,
    CMD_OK    = 2'd2
  } cmd_t;

  // result codes carried on the output tuser
  typedef enum logic [2:0] {
    ST_DIGIT   = 3'd0,
    ST_CLEAR   = 3'd1,
    ST_OPEN    = 3'd2,
    ST_ADMIN   = 3'd3,
    ST_UNKNOWN = 3'd4,
    ST_NEWCODE = 3'd5,
    ST_REJECT  = 3'd6
  } status_t;

  // configuration register indexes
  typedef enum logic [CFG_IDX_W-1:0] {
    REG_ADMIN_CODE     = 1'd0,
    REG_INIT_OPEN_CODE = 1'd1
  } cfg_reg_t;

  // lock state carried between the core and the step logic
  typedef struct packed {
    logic [CODE_W-1:0]  entry_buf;
    logic [COUNT_W-1:0] entry_cnt;
    logic [CODE_W-1:0]  open_code;
    logic               admin;
  } lock_state_t;

endpackage

// ===== rtl/kcl_step.sv =====
// ----------------------------------------------------------------------------
// kcl_step
// Combinational next state and status for one key event.
// ----------------------------------------------------------------------------
module kcl_step (
  input  kcl_pkg::lock_state_t              cur,
  input  logic [1:0]                        command,
  input  logic [kcl_pkg::DIGIT_W-1:0]       digit,
  input  logic [kcl_pkg::CODE_W-1:0]        admin_code,
  output kcl_pkg::lock_state_t              nxt,
  output kcl_pkg::status_t                  status
);

  logic full;
  logic open_hit;
  logic admin_hit;

  // a partial entry never matches a code
  assign full      = (cur.entry_cnt == kcl_pkg::COUNT_W'(kcl_pkg::CODE_DIGITS));
  assign open_hit  = full && (cur.entry_buf == cur.open_code);
  assign admin_hit = full && (cur.entry_buf == admin_code);

  // key decode
  always_comb begin
    nxt    = cur;
    status = kcl_pkg::ST_DIGIT;
    unique case (command)
      kcl_pkg::CMD_DIGIT: begin
        // digits above nine and digits past a full buffer are dropped
        if (digit <= kcl_pkg::DIGIT_W'(9) && !full) begin
          nxt.entry_buf = {cur.entry_buf[kcl_pkg::CODE_W-kcl_pkg::DIGIT_W-1:0], digit};
          nxt.entry_cnt = cur.entry_cnt + kcl_pkg::COUNT_W'(1);
        end
      end
      kcl_pkg::CMD_CLEAR: begin
        nxt.entry_buf = '0;
        nxt.entry_cnt = '0;
        status        = kcl_pkg::ST_CLEAR;
      end
      kcl_pkg::CMD_OK: begin
        nxt.entry_buf = '0;
        nxt.entry_cnt = '0;
        priority if (cur.admin) begin
          nxt.admin = 1'b0;
          if (full && !admin_hit) begin
            nxt.open_code = cur.entry_buf;
            status        = kcl_pkg::ST_NEWCODE;
          end else begin
            status = kcl_pkg::ST_REJECT;
          end
        end else if (open_hit) begin
          status = kcl_pkg::ST_OPEN;
        end else if (admin_hit) begin
          nxt.admin = 1'b1;
          status    = kcl_pkg::ST_ADMIN;
        end else begin
          status = kcl_pkg::ST_UNKNOWN;
        end
      end
      default: begin
        // unused key code: no state change
        nxt    = cur;
        status = kcl_pkg::ST_DIGIT;
      end
    endcase
  end

endmodule

// ===== rtl/keypad_code_lock_core.sv =====
// ----------------------------------------------------------------------------
// keypad_code_lock_core
// Four-digit keypad code lock with an administrator code for setting a new
// opening code.
// ----------------------------------------------------------------------------
// One key event is taken per clock cycle and its result appears on the output
// register in the cycle after the input transfer. Throughput is one item per
// cycle, set by the single step of decode and compare logic between the lock
// state registers and the output register; the output register lets a new key
// be taken while the previous result waits, as long as out_tready is high or
// the register is empty. Writing initial_open_code also reloads the active
// opening code. Configuration writes are taken in any cycle.
module keypad_code_lock_core (
  input  logic                          clk,
  input  logic                          rst_n,
  // key event channel
  input  logic                          in_tvalid,
  output logic                          in_tready,
  input  logic [7:0]                    in_tdata,   // [3:0] digit, zero padded
  input  logic [1:0]                    in_tuser,   // [1:0] command
  // result channel
  output logic                          out_tvalid,
  input  logic                          out_tready,
  output logic [7:0]                    out_tdata,  // [2:0] digits_entered,
                                                    // [3] in_admin_mode, zero padded
  output logic [2:0]                    out_tuser,  // [2:0] status
  // configuration write channel
  input  logic                          cfg_valid,
  output logic                          cfg_ready,
  input  logic [kcl_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [kcl_pkg::CODE_W-1:0]    cfg_data
);

  kcl_pkg::lock_state_t state_r;
  kcl_pkg::lock_state_t state_nxt;
  kcl_pkg::lock_state_t step_nxt;
  kcl_pkg::status_t     step_status;

  logic [kcl_pkg::CODE_W-1:0]  admin_code_r;

  logic                        out_valid_r;
  kcl_pkg::status_t            out_status_r;
  logic [kcl_pkg::COUNT_W-1:0] out_cnt_r;
  logic                        out_admin_r;

  logic in_xfer;
  logic out_xfer;
  logic cfg_xfer;

  assign in_tready = !out_valid_r || out_tready;
  assign in_xfer   = in_tvalid && in_tready;
  assign out_xfer  = out_tvalid && out_tready;
  assign cfg_ready = 1'b1;
  assign cfg_xfer  = cfg_valid && cfg_ready;

  // step logic
  kcl_step u_step (
    .cur        (state_r),
    .command    (in_tuser),
    .digit      (in_tdata[kcl_pkg::DIGIT_W-1:0]),
    .admin_code (admin_code_r),
    .nxt        (step_nxt),
    .status     (step_status)
  );

  // state update, configuration reload of the opening code wins
  always_comb begin
    state_nxt = state_r;
    if (in_xfer) begin
      state_nxt = step_nxt;
    end
    if (cfg_xfer && cfg_index == kcl_pkg::REG_INIT_OPEN_CODE) begin
      state_nxt.open_code = cfg_data;
    end
  end

  // lock state and admin code registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= '0;
      admin_code_r <= '0;
    end else begin
      state_r <= state_nxt;
      if (cfg_xfer && cfg_index == kcl_pkg::REG_ADMIN_CODE) begin
        admin_code_r <= cfg_data;
      end
    end
  end

  // output register valid
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (in_xfer) begin
      out_valid_r <= 1'b1;
    end else if (out_xfer) begin
      out_valid_r <= 1'b0;
    end
  end

  // output register payload
  always_ff @(posedge clk) begin
    if (in_xfer) begin
      out_status_r <= step_status;
      out_cnt_r    <= step_nxt.entry_cnt;
      out_admin_r  <= step_nxt.admin;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tuser  = out_status_r;
  assign out_tdata  = {4'b0000, out_admin_r, out_cnt_r};

  // entry count never passes the code length
  a_cnt_range: assert property (@(posedge clk) disable iff (!rst_n)
    state_r.entry_cnt <= kcl_pkg::COUNT_W'(kcl_pkg::CODE_DIGITS))
    else $error("entry count beyond code length");

  // every accepted key yields a result in the next cycle
  a_result_follows: assert property (@(posedge clk) disable iff (!rst_n)
    in_xfer |=> out_valid_r)
    else $error("accepted key gave no result");

  // an OK key always empties the buffer
  a_ok_empties: assert property (@(posedge clk) disable iff (!rst_n)
    (in_xfer && in_tuser == kcl_pkg::CMD_OK) |=> (state_r.entry_cnt == '0))
    else $error("buffer not emptied after OK");

  // admin mode is only entered with the admin status
  a_admin_entry: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(state_r.admin) |-> (out_valid_r && out_status_r == kcl_pkg::ST_ADMIN))
    else $error("admin mode entered without admin status");

  // reported mode matches the lock state right after a transfer
  a_mode_report: assert property (@(posedge clk) disable iff (!rst_n)
    in_xfer |=> (out_admin_r == state_r.admin))
    else $error("reported admin mode differs from state");

endmodule

// ===== tb/keypad_code_lock_core_test.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// keypad_code_lock_core_test
// Self-checking bench for the keypad code lock core. Key events are sent on
// the input stream and every result is checked field by field against a
// behavioral model of the lock kept in the bench. Directed keys cover the
// grant, admin, new-code, partial-entry and ignored-key cases; random code
// entry sequences then run under several register settings and with both
// stream sides stalling at different rates.
// ----------------------------------------------------------------------------
module keypad_code_lock_core_test;

  // key kind that the lock ignores completely
  localparam logic [1:0] CMD_NONE  = 2'd3;
  localparam int         MAX_DIGIT = 9;
  localparam int         STALL_LIMIT = 5000;
  localparam int         PHASE_ITEMS = 135;

  typedef struct packed {
    kcl_pkg::status_t            status;
    logic [kcl_pkg::COUNT_W-1:0] count;
    logic                        admin;
  } key_result_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;

  logic                          in_tvalid = 1'b0;
  logic                          in_tready;
  logic [7:0]                    in_tdata = '0;    // [3:0] digit, zero padded
  logic [1:0]                    in_tuser = '0;    // [1:0] command
  logic                          out_tvalid;
  logic                          out_tready = 1'b0;
  logic [7:0]                    out_tdata;        // [2:0] digits_entered, [3] in_admin_mode
  logic [2:0]                    out_tuser;        // [2:0] status
  logic                          cfg_valid = 1'b0;
  logic                          cfg_ready;
  logic [kcl_pkg::CFG_IDX_W-1:0] cfg_index = '0;
  logic [kcl_pkg::CODE_W-1:0]    cfg_data = '0;

  // lock model state and register copy
  logic [kcl_pkg::CODE_W-1:0]  lock_buf;
  logic [kcl_pkg::COUNT_W-1:0] lock_cnt;
  logic [kcl_pkg::CODE_W-1:0]  lock_open;
  logic                        lock_admin;
  logic [kcl_pkg::CODE_W-1:0]  admin_reg;

  key_result_t expected_q[$];
  int err_count = 0;
  int item_count = 0;
  int send_idle_pct = 0;
  int recv_idle_pct = 0;
  int stall_cycles;

  keypad_code_lock_core u_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .in_tuser  (in_tuser),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata),
    .out_tuser (out_tuser),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  always #5 clk = ~clk;

  // receiver stalls
  always @(posedge clk) begin
    out_tready <= ($urandom_range(99) >= recv_idle_pct);
  end

  // lock behavior for one key, updates the model state
  function automatic key_result_t predict_key(logic [1:0] cmd, logic [3:0] dig);
    key_result_t r;
    logic full;
    r.status = kcl_pkg::ST_DIGIT;
    full = (lock_cnt == kcl_pkg::CODE_DIGITS);
    case (cmd)
      kcl_pkg::CMD_DIGIT: begin
        if (dig <= MAX_DIGIT && lock_cnt < kcl_pkg::CODE_DIGITS) begin
          lock_buf = {lock_buf[kcl_pkg::CODE_W-kcl_pkg::DIGIT_W-1:0], dig};
          lock_cnt = lock_cnt + 1'b1;
        end
      end
      kcl_pkg::CMD_CLEAR: begin
        lock_buf = '0;
        lock_cnt = '0;
        r.status = kcl_pkg::ST_CLEAR;
      end
      kcl_pkg::CMD_OK: begin
        if (lock_admin) begin
          lock_admin = 1'b0;
          if (full && lock_buf != admin_reg) begin
            lock_open = lock_buf;
            r.status  = kcl_pkg::ST_NEWCODE;
          end else begin
            r.status = kcl_pkg::ST_REJECT;
          end
        end else if (full && lock_buf == lock_open) begin
          r.status = kcl_pkg::ST_OPEN;
        end else if (full && lock_buf == admin_reg) begin
          lock_admin = 1'b1;
          r.status   = kcl_pkg::ST_ADMIN;
        end else begin
          r.status = kcl_pkg::ST_UNKNOWN;
        end
        lock_buf = '0;
        lock_cnt = '0;
      end
      default: ;
    endcase
    r.count = lock_cnt;
    r.admin = lock_admin;
    return r;
  endfunction

  function automatic logic [kcl_pkg::CODE_W-1:0] rand_bcd_code();
    logic [kcl_pkg::CODE_W-1:0] c;
    for (int i = 0; i < kcl_pkg::CODE_DIGITS; i++) begin
      c[i*kcl_pkg::DIGIT_W +: kcl_pkg::DIGIT_W] = 4'($urandom_range(MAX_DIGIT));
    end
    return c;
  endfunction

  task automatic flag_error(string msg);
    err_count++;
    if (err_count <= 10) $display("%0t: %s", $time, msg);
  endtask

  // one key transfer, with random sender gaps
  task automatic send_key(logic [1:0] cmd, logic [3:0] dig);
    if ($urandom_range(99) < send_idle_pct) begin
      in_tvalid <= 1'b0;
      repeat ($urandom_range(1, 4)) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser  <= cmd;
    in_tdata  <= {4'b0, dig};
    do @(posedge clk); while (!in_tready);
    expected_q.push_back(predict_key(cmd, dig));
    item_count++;
  endtask

  // hold off the sender until every result has come back
  task automatic wait_drain();
    in_tvalid <= 1'b0;
    do @(posedge clk); while (expected_q.size() != 0);
  endtask

  task automatic write_reg(kcl_pkg::cfg_reg_t idx, logic [kcl_pkg::CODE_W-1:0] value);
    wait_drain();
    repeat (2) @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= value;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    if (idx == kcl_pkg::REG_ADMIN_CODE) begin
      admin_reg = value;
    end else begin
      lock_open = value;
    end
  endtask

  // keys a code first digit first, now and then with an ignored key mixed in
  task automatic key_code(logic [kcl_pkg::CODE_W-1:0] code);
    for (int i = kcl_pkg::CODE_DIGITS - 1; i >= 0; i--) begin
      if ($urandom_range(19) == 0) begin
        send_key(kcl_pkg::CMD_DIGIT, 4'($urandom_range(15, MAX_DIGIT + 1)));
      end
      send_key(kcl_pkg::CMD_DIGIT, code[i*kcl_pkg::DIGIT_W +: kcl_pkg::DIGIT_W]);
    end
  endtask

  // one random operator action
  task automatic send_sequence();
    int pick;
    logic [kcl_pkg::CODE_W-1:0] fresh;
    pick = $urandom_range(99);
    if (lock_cnt != 0 && $urandom_range(3) != 0) begin
      send_key(kcl_pkg::CMD_CLEAR, 4'($urandom_range(15)));
    end
    if (pick < 30) begin
      key_code(lock_open);
      send_key(kcl_pkg::CMD_OK, 4'($urandom_range(15)));
    end else if (pick < 60) begin
      key_code(admin_reg);
      send_key(kcl_pkg::CMD_OK, 4'($urandom_range(15)));
      if ($urandom_range(9) < 8) begin
        fresh = ($urandom_range(4) == 0) ? admin_reg : rand_bcd_code();
        if ($urandom_range(5) == 0) begin
          repeat ($urandom_range(3)) begin
            send_key(kcl_pkg::CMD_DIGIT, 4'($urandom_range(MAX_DIGIT)));
          end
        end else begin
          key_code(fresh);
        end
        if ($urandom_range(7) == 0) send_key(kcl_pkg::CMD_CLEAR, 4'($urandom_range(15)));
        send_key(kcl_pkg::CMD_OK, 4'($urandom_range(15)));
      end
    end else if (pick < 80) begin
      repeat ($urandom_range(6)) begin
        send_key(kcl_pkg::CMD_DIGIT, 4'(($urandom_range(5) == 0) ? $urandom_range(15) :
                                        $urandom_range(MAX_DIGIT)));
      end
      send_key($urandom_range(1) ? kcl_pkg::CMD_OK : kcl_pkg::CMD_CLEAR,
               4'($urandom_range(15)));
    end else begin
      repeat ($urandom_range(1, 4)) send_key(2'($urandom_range(3)), 4'($urandom_range(15)));
    end
    if ($urandom_range(29) == 0) wait_drain();
  endtask

  // register settings, extremes included
  task automatic apply_setting(int k);
    logic [kcl_pkg::CODE_W-1:0] c;
    case (k)
      0: begin
        write_reg(kcl_pkg::REG_ADMIN_CODE, rand_bcd_code());
        write_reg(kcl_pkg::REG_INIT_OPEN_CODE, rand_bcd_code());
      end
      1: begin
        write_reg(kcl_pkg::REG_ADMIN_CODE, 16'h0000);
        write_reg(kcl_pkg::REG_INIT_OPEN_CODE, 16'h9999);
      end
      2: begin
        write_reg(kcl_pkg::REG_ADMIN_CODE, 16'h9999);
        write_reg(kcl_pkg::REG_INIT_OPEN_CODE, 16'h0000);
      end
      3: begin
        write_reg(kcl_pkg::REG_ADMIN_CODE, 16'hFFFF);
        write_reg(kcl_pkg::REG_INIT_OPEN_CODE, rand_bcd_code());
      end
      4: begin
        write_reg(kcl_pkg::REG_ADMIN_CODE, rand_bcd_code());
        write_reg(kcl_pkg::REG_INIT_OPEN_CODE, 16'hFFFF);
      end
      default: begin
        // admin and opening code equal: grant wins
        c = rand_bcd_code();
        write_reg(kcl_pkg::REG_ADMIN_CODE, c);
        write_reg(kcl_pkg::REG_INIT_OPEN_CODE, c);
      end
    endcase
  endtask

  // result checker
  always @(posedge clk) begin
    key_result_t want;
    key_result_t got;
    if (rst_n && out_tvalid && out_tready) begin
      got.status = kcl_pkg::status_t'(out_tuser);
      got.count  = out_tdata[2:0];
      got.admin  = out_tdata[3];
      if (expected_q.size() == 0) begin
        flag_error($sformatf("unexpected result status %0d count %0d admin %0d",
                             out_tuser, got.count, got.admin));
      end else begin
        want = expected_q.pop_front();
        if (got !== want) begin
          flag_error($sformatf("expected status %0d count %0d admin %0d, got %0d %0d %0d",
                               want.status, want.count, want.admin,
                               out_tuser, got.count, got.admin));
        end
      end
    end
  end

  // watchdog on cycles without any transfer
  initial begin
    stall_cycles = 0;
    while (stall_cycles < STALL_LIMIT) begin
      @(posedge clk);
      if (!rst_n || (in_tvalid && in_tready) || (out_tvalid && out_tready) ||
          (cfg_valid && cfg_ready)) begin
        stall_cycles = 0;
      end else begin
        stall_cycles++;
      end
    end
    $display("TB_ERROR");
    $finish;
  end

  // reset opening code is zero, so four zeros open the lock
  task automatic test_reset_code();
    key_code(16'h0000);
    send_key(kcl_pkg::CMD_OK, 4'd0);
  endtask

  task automatic test_directed_keys();
    write_reg(kcl_pkg::REG_ADMIN_CODE, 16'h1234);
    write_reg(kcl_pkg::REG_INIT_OPEN_CODE, 16'h5678);
    // admin entry, clear keeps admin mode
    key_code(16'h1234);
    send_key(kcl_pkg::CMD_OK, 4'd0);
    send_key(kcl_pkg::CMD_CLEAR, 4'd9);
    // new code with an out-of-range digit and a digit past a full buffer
    send_key(kcl_pkg::CMD_DIGIT, 4'd9);
    send_key(kcl_pkg::CMD_DIGIT, 4'd10);
    send_key(kcl_pkg::CMD_DIGIT, 4'd8);
    send_key(kcl_pkg::CMD_DIGIT, 4'd7);
    send_key(kcl_pkg::CMD_DIGIT, 4'd6);
    send_key(kcl_pkg::CMD_DIGIT, 4'd0);
    send_key(kcl_pkg::CMD_OK, 4'd15);
    // partial entry in normal mode, plus the ignored command
    send_key(kcl_pkg::CMD_DIGIT, 4'd3);
    send_key(CMD_NONE, 4'd15);
    send_key(kcl_pkg::CMD_OK, 4'd0);
    // partial entry in admin mode is rejected
    key_code(16'h1234);
    send_key(kcl_pkg::CMD_OK, 4'd0);
    send_key(kcl_pkg::CMD_DIGIT, 4'd15);
    send_key(kcl_pkg::CMD_OK, 4'd0);
  endtask

  task automatic test_random_phase(int send_pct, int recv_pct, int first_setting);
    send_idle_pct = send_pct;
    recv_idle_pct = recv_pct;
    for (int s = 0; s < 2; s++) begin
      apply_setting(first_setting + s);
      item_count = 0;
      while (item_count < PHASE_ITEMS) send_sequence();
    end
  endtask

  initial begin
    lock_buf   = '0;
    lock_cnt   = '0;
    lock_open  = '0;
    lock_admin = 1'b0;
    admin_reg  = '0;
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_reset_code();
    test_directed_keys();
    test_random_phase(16, 70, 0);
    test_random_phase(70, 16, 2);
    test_random_phase(0, 0, 4);
    wait_drain();
    repeat (10) @(posedge clk);
    if (err_count == 0 && expected_q.size() == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule
